[rtl/pwlwc_pkg.sv]
// Package with the widths, constants and curve tables of the weight calibration unit.
`timescale 1ns / 1ps

package pwlwc_pkg;

   localparam int NumPoints = 9;
   localparam int NumRegs   = 8;
   localparam int DataW     = 32;
   localparam int RawW      = 31;
   localparam int RegIdxW   = $clog2(NumRegs);
   localparam int CsrIdxW   = RegIdxW + 1;
   localparam int PtIdxW    = $clog2(NumPoints);
   localparam int SegW      = $clog2(NumPoints - 1);
   localparam int WeightW   = 14;
   localparam int NumW      = RawW + WeightW;
   localparam int RemW      = RawW + 1;
   localparam int DivCntW   = $clog2(NumW);
   localparam int StateW    = 3;

   function automatic logic [WeightW-1:0] point_weight(input logic [PtIdxW-1:0] idx);
      logic [WeightW-1:0] w;
      case (idx)
         4'd1:    w = WeightW'(218);
         4'd2:    w = WeightW'(268);
         4'd3:    w = WeightW'(418);
         4'd4:    w = WeightW'(718);
         4'd5:    w = WeightW'(1218);
         4'd6:    w = WeightW'(2218);
         4'd7:    w = WeightW'(5218);
         4'd8:    w = WeightW'(10218);
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [RawW-1:0] raw_reset(input logic [RegIdxW-1:0] idx);
      logic [RawW-1:0] v;
      case (idx)
         3'd0:    v = RawW'(218);
         3'd1:    v = RawW'(268);
         3'd2:    v = RawW'(418);
         3'd3:    v = RawW'(718);
         3'd4:    v = RawW'(1218);
         3'd5:    v = RawW'(2218);
         3'd6:    v = RawW'(5218);
         3'd7:    v = RawW'(10218);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/pwlwc_req_if.sv]
// Request channel interface carrying the two raw readings.
`timescale 1ns / 1ps

interface pwlwc_req_if;
   import pwlwc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] current_raw;
   logic signed [DataW-1:0] zero_raw;

   modport source (output valid, output current_raw, output zero_raw, input ready);
   modport sink   (input valid, input current_raw, input zero_raw, output ready);
endinterface

[rtl/pwlwc_rsp_if.sv]
// Response channel interface carrying the gross and net weights.
`timescale 1ns / 1ps

interface pwlwc_rsp_if;
   import pwlwc_pkg::*;

   logic             valid;
   logic             ready;
   logic [DataW-1:0] gross_tenths;
   logic [DataW-1:0] net_tenths;

   modport source (output valid, output gross_tenths, output net_tenths, input ready);
   modport sink   (input valid, input gross_tenths, input net_tenths, output ready);
endinterface

[rtl/piecewise_linear_weight_calibration_unit.sv]
// Top level of the piecewise-linear weight calibration unit.
// The request channel carries a current and a session-zero raw reading, both signed and
// relative to the empty scale. Each reading is converted to tenths of grams on a nine-point
// curve whose raw breakpoints are written through the csr write port (index 0 to 7).
// The response channel returns the gross weight and the net weight, gross minus tare
// floored at zero. One transaction in gives exactly one transaction out.
// The two readings are converted one after the other by a single shared datapath: a serial
// search over the breakpoints, a multiply in the setup state and a restoring divider that
// retires one quotient bit per cycle. A reading at or below zero skips the search and the
// division. The block takes one transaction at a time and its ready is low while it works.
// A finished result sits in an output register, so the next request is taken while the
// receiver stalls; the block waits only if a second result is ready before the first has
// left. Reset is synchronous and active high: it returns the sequencer to idle, drops the
// response valid and loads the default breakpoints.
`timescale 1ns / 1ps

module piecewise_linear_weight_calibration_unit (
   input  logic                          clock,
   input  logic                          reset,
   pwlwc_req_if.sink                     req,
   pwlwc_rsp_if.source                   rsp,
   input  logic                          csr_wen,
   input  logic [pwlwc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pwlwc_pkg::RawW-1:0]    csr_wdata
);
   import pwlwc_pkg::*;

   localparam logic [StateW-1:0] ST_IDLE   = 3'd0;
   localparam logic [StateW-1:0] ST_START  = 3'd1;
   localparam logic [StateW-1:0] ST_SEARCH = 3'd2;
   localparam logic [StateW-1:0] ST_SETUP  = 3'd3;
   localparam logic [StateW-1:0] ST_DIV    = 3'd4;
   localparam logic [StateW-1:0] ST_FINISH = 3'd5;
   localparam logic [StateW-1:0] ST_OUTPUT = 3'd6;

   localparam logic [SegW-1:0] LastSeg = SegW'(NumPoints - 2);

   logic [StateW-1:0]  state_ff, state_in;
   logic               sel_ff, sel_in;
   logic [SegW-1:0]    seg_ff, seg_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [DataW-1:0]   cur_ff, cur_in;
   logic [DataW-1:0]   zer_ff, zer_in;
   logic [RawW-1:0]    r_ff, r_in;
   logic [RawW-1:0]    lo_raw_ff, lo_raw_in;
   logic [RawW-1:0]    hi_raw_ff, hi_raw_in;
   logic [RawW-1:0]    span_ff, span_in;
   logic [NumW-1:0]    num_ff, num_in;
   logic [RemW-1:0]    rem_ff, rem_in;
   logic [DataW-1:0]   gross_ff, gross_in;
   logic [DataW-1:0]   tare_ff, tare_in;
   logic [DataW-1:0]   rsp_gross_ff, rsp_gross_in;
   logic [DataW-1:0]   rsp_net_ff, rsp_net_in;

   logic [RawW-1:0]    raw_ff [NumRegs];

   logic [DataW-1:0]   reading;
   logic [RawW-1:0]    cur_hi;
   logic [PtIdxW-1:0]  pt_lo;
   logic [PtIdxW-1:0]  pt_hi;
   logic [WeightW-1:0] w_lo;
   logic [WeightW-1:0] w_span;
   logic [DataW-1:0]   span_s;
   logic [RawW-1:0]    diff;
   logic [RemW-1:0]    trial;
   logic               trial_ge;
   logic [NumW:0]      sum;
   logic [DataW-1:0]   sat;
   logic               out_free;

   assign reading  = sel_ff ? zer_ff : cur_ff;
   assign cur_hi   = raw_ff[seg_ff];
   assign pt_lo    = PtIdxW'(seg_ff);
   assign pt_hi    = PtIdxW'(seg_ff) + PtIdxW'(1);
   assign w_lo     = point_weight(pt_lo);
   assign w_span   = point_weight(pt_hi) - point_weight(pt_lo);
   assign span_s   = {1'b0, hi_raw_ff} - {1'b0, lo_raw_ff};
   assign diff     = r_ff - lo_raw_ff;
   assign trial    = {rem_ff[RemW-2:0], num_ff[NumW-1]};
   assign trial_ge = trial >= {1'b0, span_ff};
   assign sum      = {1'b0, num_ff} + (NumW+1)'(w_lo);
   assign sat      = (|sum[NumW:DataW]) ? '1 : sum[DataW-1:0];
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.gross_tenths = rsp_gross_ff;
   assign rsp.net_tenths   = rsp_net_ff;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      seg_in       = seg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cur_in       = cur_ff;
      zer_in       = zer_ff;
      r_in         = r_ff;
      lo_raw_in    = lo_raw_ff;
      hi_raw_in    = hi_raw_ff;
      span_in      = span_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      gross_in     = gross_ff;
      tare_in      = tare_ff;
      rsp_gross_in = rsp_gross_ff;
      rsp_net_in   = rsp_net_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cur_in   = req.current_raw;
               zer_in   = req.zero_raw;
               sel_in   = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (reading[DataW-1] || reading == '0) begin
               seg_in   = '0;
               num_in   = '0;
               state_in = ST_FINISH;
            end else begin
               r_in      = reading[RawW-1:0];
               seg_in    = '0;
               lo_raw_in = '0;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (r_ff <= cur_hi || seg_ff == LastSeg) begin
               hi_raw_in = cur_hi;
               state_in  = ST_SETUP;
            end else begin
               lo_raw_in = cur_hi;
               seg_in    = seg_ff + SegW'(1);
            end
         end
         ST_SETUP: begin
            if (span_s[DataW-1] || span_s == '0) begin
               num_in   = '0;
               state_in = ST_FINISH;
            end else begin
               span_in  = span_s[RawW-1:0];
               num_in   = NumW'(diff) * NumW'(w_span) + NumW'(span_s[RawW-1:1]);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? (trial - {1'b0, span_ff}) : trial;
            num_in = {num_ff[NumW-2:0], trial_ge};
            cnt_in = cnt_ff + DivCntW'(1);
            if (cnt_ff == DivCntW'(NumW - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!sel_ff) begin
               gross_in = sat;
               sel_in   = 1'b1;
               state_in = ST_START;
            end else begin
               tare_in  = sat;
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_gross_in = gross_ff;
               rsp_net_in   = (gross_ff > tare_ff) ? (gross_ff - tare_ff) : '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         seg_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         seg_ff       <= seg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      zer_ff       <= zer_in;
      r_ff         <= r_in;
      lo_raw_ff    <= lo_raw_in;
      hi_raw_ff    <= hi_raw_in;
      span_ff      <= span_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      gross_ff     <= gross_in;
      tare_ff      <= tare_in;
      rsp_gross_ff <= rsp_gross_in;
      rsp_net_ff   <= rsp_net_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            raw_ff[i] <= raw_reset(RegIdxW'(i));
         end
      end else if (csr_wen && csr_index < CsrIdxW'(NumRegs)) begin
         raw_ff[csr_index[RegIdxW-1:0]] <= csr_wdata;
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == ST_START)
      else $error("sequencer did not start after an accepted transaction");

   a_net_not_above_gross: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_net_ff <= rsp_gross_ff)
      else $error("net weight exceeds gross weight");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> seg_ff <= LastSeg)
      else $error("segment search ran past the last segment");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < {1'b0, span_ff})
      else $error("divider remainder not below the span");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff <= DivCntW'(NumW - 1))
      else $error("divider step count out of range");
`endif

endmodule

[tb/pwlwc_weight_checker.sv]
// Checker that predicts the gross and net weights and compares every response transaction.
`timescale 1ns / 1ps

module pwlwc_weight_checker (
   input  logic                          clock,
   input  logic                          reset,
   pwlwc_req_if                          req,
   pwlwc_rsp_if                          rsp,
   input  logic                          csr_wen,
   input  logic [pwlwc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pwlwc_pkg::RawW-1:0]    csr_wdata,
   output int unsigned                   mismatch_count,
   output int unsigned                   pending_count,
   output int unsigned                   checked_count,
   output int unsigned                   saturated_count,
   output int unsigned                   floored_count
);
   import pwlwc_pkg::*;

   typedef struct packed {
      logic [DataW-1:0] gross;
      logic [DataW-1:0] net;
   } weight_pair_type;

   localparam longint TenthsMax = 64'h0000_0000_FFFF_FFFF;

   logic [RawW-1:0] breakpoints [NumRegs];
   weight_pair_type expected_weights [$];
   int unsigned     errors = 0;
   int unsigned     checked = 0;
   int unsigned     saturated = 0;
   int unsigned     floored = 0;

   function automatic longint tenths_at(input int idx);
      case (idx)
         1:       return 218;
         2:       return 268;
         3:       return 418;
         4:       return 718;
         5:       return 1218;
         6:       return 2218;
         7:       return 5218;
         8:       return 10218;
         default: return 0;
      endcase
   endfunction

   function automatic longint breakpoint_raw(input int idx);
      if (idx == 0) begin
         return 0;
      end
      return longint'(breakpoints[idx - 1]);
   endfunction

   function automatic logic [DataW-1:0] reading_to_tenths(input logic [DataW-1:0] reading);
      longint r;
      longint lo_raw;
      longint span;
      longint v;
      int     seg;
      if (reading[DataW-1] || reading == '0) begin
         return '0;
      end
      r = longint'(reading);
      // Readings beyond every breakpoint extrapolate on the last segment.
      seg = NumPoints - 2;
      for (int i = NumPoints - 2; i >= 0; i--) begin
         if (r <= breakpoint_raw(i + 1)) begin
            seg = i;
         end
      end
      lo_raw = breakpoint_raw(seg);
      span   = breakpoint_raw(seg + 1) - lo_raw;
      if (span <= 0) begin
         return DataW'(tenths_at(seg));
      end
      v = tenths_at(seg)
          + ((r - lo_raw) * (tenths_at(seg + 1) - tenths_at(seg)) + span / 2) / span;
      if (v <= 0) begin
         return '0;
      end
      if (v > TenthsMax) begin
         return '1;
      end
      return DataW'(v);
   endfunction

   always @(posedge clock) begin : monitor
      weight_pair_type  got;
      weight_pair_type  want;
      logic [DataW-1:0] tare;
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            breakpoints[i] = RawW'(tenths_at(i + 1));
         end
         expected_weights.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.gross = rsp.gross_tenths;
            got.net   = rsp.net_tenths;
            if (expected_weights.size() == 0) begin
               errors++;
               $display("%0t: response transaction with none expected, gross %0d net %0d",
                        $time, got.gross, got.net);
            end else begin
               want = expected_weights.pop_front();
               checked++;
               if (got.gross !== want.gross) begin
                  errors++;
                  $display("%0t: gross_tenths expected %0d, actual %0d",
                           $time, want.gross, got.gross);
               end
               if (got.net !== want.net) begin
                  errors++;
                  $display("%0t: net_tenths expected %0d, actual %0d",
                           $time, want.net, got.net);
               end
            end
         end
         if (req.valid && req.ready) begin
            want.gross = reading_to_tenths(req.current_raw);
            tare       = reading_to_tenths(req.zero_raw);
            want.net   = (want.gross > tare) ? want.gross - tare : '0;
            if (want.gross == '1) begin
               saturated++;
            end
            if (tare != '0 && tare >= want.gross) begin
               floored++;
            end
            expected_weights.push_back(want);
         end
         if (csr_wen && csr_index < CsrIdxW'(NumRegs)) begin
            breakpoints[csr_index[RegIdxW-1:0]] = csr_wdata;
         end
      end
      mismatch_count  <= errors;
      pending_count   <= expected_weights.size();
      checked_count   <= checked;
      saturated_count <= saturated;
      floored_count   <= floored;
   end

endmodule

[tb/piecewise_linear_weight_calibration_unit_tb.sv]
// Testbench top that drives readings and breakpoint curves into the calibration unit.
`timescale 1ns / 1ps

module piecewise_linear_weight_calibration_unit_tb;
   import pwlwc_pkg::*;

   typedef enum int {
      CurveDefault,
      CurveWide,
      CurveTiny,
      CurveShuffled,
      CurveAllMax,
      CurveAllOne,
      CurveModerate
   } curve_type;

   localparam logic [CsrIdxW-1:0] RawPoint1Idx   = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] RawPoint8Idx   = CsrIdxW'(NumRegs - 1);
   localparam logic [CsrIdxW-1:0] FirstUnusedIdx = CsrIdxW'(NumRegs);
   localparam logic [CsrIdxW-1:0] LastUnusedIdx  = '1;
   localparam int NumPhases     = 8;
   localparam int ItemsPerPhase = 190;
   localparam int CalmStretch   = 40;
   localparam int HoldOffCycles = 400;
   localparam int WatchdogLimit = 5000;
   localparam int SettleCycles  = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               csr_wen;
   logic [CsrIdxW-1:0] csr_index;
   logic [RawW-1:0]    csr_wdata;

   pwlwc_req_if req_if ();
   pwlwc_rsp_if rsp_if ();

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned saturated_count;
   int unsigned floored_count;

   logic [RawW-1:0] curve_raw [NumRegs];
   longint          curve_peak = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     csr_writes = 0;
   int unsigned     unused_writes = 0;
   int unsigned     curves_applied = 1;
   bit              hold_off_request = 1'b0;
   bit              sender_calm = 1'b0;

   piecewise_linear_weight_calibration_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pwlwc_weight_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_if),
      .rsp             (rsp_if),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .saturated_count (saturated_count),
      .floored_count   (floored_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
         $display("piecewise_linear_weight_calibration_unit: mismatch");
         $finish;
      end
   end

   function automatic int unsigned random_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 0;
         6, 7, 8:          return $urandom_range(1, 3);
         default:          return $urandom_range(8, 40);
      endcase
   endfunction

   function automatic logic [DataW-1:0] pick_reading();
      longint base;
      case ($urandom_range(0, 9))
         0: return {1'b1, 31'($urandom)};
         1: begin
            case ($urandom_range(0, 4))
               0:       return '0;
               1:       return 32'd1;
               2:       return 32'h7FFF_FFFF;
               3:       return 32'h8000_0000;
               default: return '1;
            endcase
         end
         2, 3: return $urandom;
         4, 5, 6: begin
            base = longint'(curve_raw[$urandom_range(0, NumRegs - 1)])
                   + longint'($urandom_range(0, 6)) - 3;
         end
         default: begin
            base = longint'($urandom_range(1, 32'(curve_peak + curve_peak / 8 + 16)));
         end
      endcase
      if (base > 64'sh7FFF_FFFF) begin
         base = 64'sh7FFF_FFFF;
      end
      return DataW'(base);
   endfunction

   task automatic write_register(input logic [CsrIdxW-1:0] idx, input logic [RawW-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_writes++;
      if (idx < FirstUnusedIdx) begin
         curve_raw[idx[RegIdxW-1:0]] = value;
      end else begin
         unused_writes++;
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic offer_reading(input logic [DataW-1:0] cur, input logic [DataW-1:0] zero);
      int unsigned gap;
      gap = sender_calm ? 0 : random_gap();
      req_if.valid       <= 1'b1;
      req_if.current_raw <= cur;
      req_if.zero_raw    <= zero;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic apply_curve(input curve_type kind);
      longint          run;
      logic [RawW-1:0] value;
      wait_idle();
      write_register(FirstUnusedIdx + CsrIdxW'($urandom_range(0, LastUnusedIdx - FirstUnusedIdx)),
                     RawW'($urandom));
      run = 0;
      for (int i = 0; i < NumRegs; i++) begin
         case (kind)
            CurveWide: begin
               run  += $urandom_range(1, 32'h0FFF_FFFF);
               value = RawW'(run);
            end
            CurveTiny: begin
               run  += $urandom_range(1, 25);
               value = RawW'(run);
            end
            CurveModerate: begin
               run  += $urandom_range(1, 5000);
               value = RawW'(run);
            end
            CurveShuffled: begin
               case ($urandom_range(0, 3))
                  0:       value = '0;
                  1:       value = RawW'($urandom_range(1, 20000));
                  default: value = RawW'($urandom);
               endcase
            end
            CurveAllMax: value = '1;
            CurveAllOne: value = RawW'(1);
            default:     value = raw_reset(RegIdxW'(i));
         endcase
         write_register(RawPoint1Idx + CsrIdxW'(i), value);
      end
      csr_wen <= 1'b0;
      curve_peak = 0;
      for (int i = 0; i < NumRegs; i++) begin
         if (longint'(curve_raw[i]) > curve_peak) begin
            curve_peak = longint'(curve_raw[i]);
         end
      end
      curves_applied++;
   endtask

   initial begin : receiver
      int unsigned stall_left;
      int unsigned mode_left;
      bit          calm;
      stall_left = 0;
      mode_left  = 0;
      calm       = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(100, 400);
         end
         mode_left--;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = HoldOffCycles;
         end
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0) begin
               stall_left = random_gap();
            end
         end
      end
   end

   initial begin : stimulus
      logic [DataW-1:0] cur;
      logic [DataW-1:0] zero;
      req_if.valid       <= 1'b0;
      req_if.current_raw <= '0;
      req_if.zero_raw    <= '0;
      csr_wen            <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      for (int i = 0; i < NumRegs; i++) begin
         curve_raw[i] = raw_reset(RegIdxW'(i));
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_reading(32'd0, 32'd0);
      offer_reading(32'd1, 32'd0);
      offer_reading(32'd217, 32'd0);
      offer_reading(32'd218, 32'd0);
      offer_reading(32'd219, 32'd0);
      offer_reading(32'd10218, 32'd218);
      offer_reading(32'd10219, 32'd0);
      offer_reading(32'h7FFF_FFFF, 32'd0);
      offer_reading(32'h8000_0000, 32'd0);
      offer_reading(32'hFFFF_FFFF, 32'd5);
      offer_reading(32'd500, 32'd1000);
      offer_reading(32'd1000, 32'd500);
      offer_reading(32'd0, 32'h7FFF_FFFF);

      // A zero first breakpoint, a last segment that runs backward, and writes to unused
      // indexes that must leave the curve alone.
      wait_idle();
      write_register(RawPoint1Idx, '0);
      write_register(RawPoint8Idx, RawW'(5000));
      write_register(FirstUnusedIdx, '1);
      write_register(LastUnusedIdx, '1);
      csr_wen <= 1'b0;
      curves_applied++;
      offer_reading(32'd1, 32'd0);
      offer_reading(32'd100, 32'd0);
      offer_reading(32'd5218, 32'd0);
      offer_reading(32'd5219, 32'd0);
      offer_reading(32'h7FFF_FFFF, 32'd1);

      // A last segment one count wide drives large readings into saturation.
      wait_idle();
      write_register(RawPoint8Idx, RawW'(5219));
      csr_wen <= 1'b0;
      curves_applied++;
      offer_reading(32'd6000, 32'd0);
      offer_reading(32'h7FFF_FFFF, 32'd0);
      offer_reading(32'h7FFF_FFFF, 32'h7FFF_FFFF);

      for (int p = 0; p < NumPhases; p++) begin
         apply_curve((p == NumPhases - 1) ? CurveDefault : curve_type'(p));
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (n % CalmStretch == 0) begin
               sender_calm = ($urandom_range(0, 3) == 0);
            end
            if (p == 0 && n == 20) begin
               hold_off_request = 1'b1;
               sender_calm      = 1'b1;
            end
            cur  = pick_reading();
            zero = ($urandom_range(0, 1) != 0) ? pick_reading()
                                                : DataW'($signed(cur) >>> $urandom_range(1, 12));
            offer_reading(cur, zero);
         end
      end

      wait_idle();
      repeat (SettleCycles) @(posedge clock);
      $display("Checked %0d responses over %0d breakpoint curves,", checked_count,
               curves_applied);
      $display("%0d register writes (%0d unused).", csr_writes, unused_writes);
      $display("Gross weights saturated: %0d; net weights floored at zero by the tare: %0d.",
               saturated_count, floored_count);
      if (mismatch_count == 0) begin
         $display("piecewise_linear_weight_calibration_unit: match");
      end else begin
         $display("piecewise_linear_weight_calibration_unit: mismatch");
      end
      $finish;
   end

endmodule
